@@ design/sctc_pkg.sv @@
// Shared constants for the scancode translator: scancode values, character codes
// and the four character lookup tables (Latin/Cyrillic, lower/upper).
// No dependencies.
package sctc_pkg;

  typedef logic [7:0] char_t;

  // Number of scancodes covered by the lookup tables.
  localparam int TABLE_DEPTH = 96;
  localparam int TABLE_IDX_W = $clog2(TABLE_DEPTH);

  // Scancodes with special handling.
  localparam char_t SC_PREFIX      = 8'hE0;
  localparam char_t SC_UP          = 8'h48;
  localparam char_t SC_DOWN        = 8'h50;
  localparam char_t SC_LEFT        = 8'h4B;
  localparam char_t SC_RIGHT       = 8'h4D;
  localparam char_t SC_LSHIFT      = 8'h2A;
  localparam char_t SC_RSHIFT      = 8'h36;
  localparam char_t SC_LSHIFT_REL  = 8'hAA;
  localparam char_t SC_RSHIFT_REL  = 8'hB6;
  localparam char_t SC_CTRL        = 8'h1D;
  localparam char_t SC_CTRL_REL    = 8'h9D;
  localparam char_t SC_ALT         = 8'h38;
  localparam char_t SC_ALT_REL     = 8'hB8;
  localparam char_t SC_CAPS        = 8'h3A;
  localparam char_t SC_ENTER       = 8'h1C;
  localparam char_t SC_BACKSPACE   = 8'h0E;
  localparam char_t SC_TAB         = 8'h0F;
  localparam char_t SC_SPACE       = 8'h39;
  localparam char_t SC_ESCAPE      = 8'h01;

  // Character codes produced for special keys.
  localparam char_t CH_NONE        = 8'h00;
  localparam char_t CH_UP          = 8'h1E;
  localparam char_t CH_DOWN        = 8'h1F;
  localparam char_t CH_LEFT        = 8'h1A;
  localparam char_t CH_RIGHT       = 8'h1B;
  localparam char_t CH_NEWLINE     = 8'h0A;
  localparam char_t CH_BACKSPACE   = 8'h08;
  localparam char_t CH_TAB         = 8'h09;
  localparam char_t CH_SPACE       = 8'h20;
  localparam char_t CH_ESCAPE      = 8'h1B;

  // Letter ranges and the offset between cases.
  localparam char_t CH_LOWER_A     = 8'h61;
  localparam char_t CH_LOWER_Z     = 8'h7A;
  localparam char_t CH_UPPER_A     = 8'h41;
  localparam char_t CH_UPPER_Z     = 8'h5A;
  localparam char_t CASE_OFFSET    = 8'h20;

  localparam char_t LAT_LO [TABLE_DEPTH] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
    8'h71, 8'h77, 8'h65, 8'h72, 8'h74, 8'h79, 8'h75, 8'h69,
    8'h6F, 8'h70, 8'h5B, 8'h5D, 8'h0A, 8'h00, 8'h61, 8'h73,
    8'h64, 8'h66, 8'h67, 8'h68, 8'h6A, 8'h6B, 8'h6C, 8'h3B,
    8'h27, 8'h60, 8'h00, 8'h5C, 8'h7A, 8'h78, 8'h63, 8'h76,
    8'h62, 8'h6E, 8'h6D, 8'h2C, 8'h2E, 8'h2F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam char_t LAT_UP [TABLE_DEPTH] = '{
    8'h00, 8'h00, 8'h21, 8'h40, 8'h23, 8'h24, 8'h25, 8'h5E,
    8'h26, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
    8'h51, 8'h57, 8'h45, 8'h52, 8'h54, 8'h59, 8'h55, 8'h49,
    8'h4F, 8'h50, 8'h7B, 8'h7D, 8'h0A, 8'h00, 8'h41, 8'h53,
    8'h44, 8'h46, 8'h47, 8'h48, 8'h4A, 8'h4B, 8'h4C, 8'h3A,
    8'h22, 8'h7E, 8'h00, 8'h7C, 8'h5A, 8'h58, 8'h43, 8'h56,
    8'h42, 8'h4E, 8'h4D, 8'h3C, 8'h3E, 8'h3F, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam char_t CYR_LO [TABLE_DEPTH] = '{
    8'h00, 8'h00, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36,
    8'h37, 8'h38, 8'h39, 8'h30, 8'h2D, 8'h3D, 8'h00, 8'h00,
    8'hA9, 8'hE6, 8'hE3, 8'hAA, 8'hA5, 8'hAD, 8'hA3, 8'hE8,
    8'hE9, 8'hA7, 8'hE5, 8'hEA, 8'h0A, 8'h00, 8'hE4, 8'hEB,
    8'hA2, 8'hA0, 8'hAF, 8'hE0, 8'hAE, 8'hAB, 8'hA4, 8'hA6,
    8'hED, 8'h5C, 8'h00, 8'h5C, 8'hF1, 8'hE7, 8'hE1, 8'hAC,
    8'hA8, 8'hE2, 8'hEC, 8'hA1, 8'hEE, 8'h2E, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  localparam char_t CYR_UP [TABLE_DEPTH] = '{
    8'h00, 8'h00, 8'h21, 8'h22, 8'hFC, 8'h3B, 8'h25, 8'h3A,
    8'h3F, 8'h2A, 8'h28, 8'h29, 8'h5F, 8'h2B, 8'h00, 8'h00,
    8'h89, 8'h96, 8'h93, 8'h8A, 8'h85, 8'h8D, 8'h83, 8'h98,
    8'h99, 8'h87, 8'h95, 8'h9A, 8'h0A, 8'h00, 8'h94, 8'h9B,
    8'h82, 8'h80, 8'h8F, 8'h90, 8'h8E, 8'h8B, 8'h84, 8'h86,
    8'h9D, 8'h2F, 8'h00, 8'h2F, 8'hF0, 8'h97, 8'h91, 8'h8C,
    8'h88, 8'h92, 8'h9C, 8'h81, 8'h9E, 8'h2E, 8'h00, 8'h2A,
    8'h00, 8'h20, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h37,
    8'h38, 8'h39, 8'h2D, 8'h34, 8'h35, 8'h36, 8'h2B, 8'h31,
    8'h32, 8'h33, 8'h30, 8'h2E, 8'h00, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Table lookup; scancodes past the end of the tables give no character.
  function automatic char_t table_lookup(input char_t sc, input logic cyrillic,
                                         input logic upper);
    logic [TABLE_IDX_W-1:0] idx;
    char_t                  res;
    idx = sc[TABLE_IDX_W-1:0];
    res = CH_NONE;
    if (32'(sc) < TABLE_DEPTH) begin
      if (cyrillic) begin
        res = upper ? CYR_UP[idx] : CYR_LO[idx];
      end else begin
        res = upper ? LAT_UP[idx] : LAT_LO[idx];
      end
    end
    return res;
  endfunction

endpackage

@@ design/scancode_to_char_translator.sv @@
// Top level of the scancode translator: modifier flag registers, translation
// logic and the result register. Depends on sctc_pkg.
//
// The result is registered: it appears in the cycle after its scancode is accepted.
// Throughput: one scancode per cycle; the result register refills in the cycle
// it is emptied, and input stall is raised only while a result waits stalled.
// The whole translation is one table lookup plus a case fix between registers.
// Reset (rst, synchronous): all modifier flags, the prefix flag and out_valid clear.
module scancode_to_char_translator
  import sctc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] scancode,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] char_code,
  output logic       shift_held,
  output logic       ctrl_held,
  output logic       alt_held,
  output logic       caps_on,
  output logic       alt_layout
);

  logic  in_acc;
  logic  shift_flag, ctrl_flag, alt_flag, caps_flag, prefix_pending, layout_flag;
  logic  shift_flag_next, ctrl_flag_next, alt_flag_next, caps_flag_next;
  logic  prefix_pending_next, layout_flag_next;
  char_t char_next;
  char_t looked_up;
  char_t char_reg;

  // An item enters whenever the result register is free or being emptied.
  assign in_stall = out_valid & out_stall;
  assign in_acc   = in_valid & ~in_stall;

  assign looked_up = table_lookup(scancode, layout_flag, shift_flag);

  // Translation of one scancode and the flag updates it causes.
  always_comb begin
    shift_flag_next     = shift_flag;
    ctrl_flag_next      = ctrl_flag;
    alt_flag_next       = alt_flag;
    caps_flag_next      = caps_flag;
    prefix_pending_next = prefix_pending;
    layout_flag_next    = layout_flag;
    char_next           = CH_NONE;
    if (scancode == SC_PREFIX) begin
      prefix_pending_next = 1'b1;
    end else if (prefix_pending) begin
      prefix_pending_next = 1'b0;
      case (scancode)
        SC_UP:    char_next = CH_UP;
        SC_DOWN:  char_next = CH_DOWN;
        SC_LEFT:  char_next = CH_LEFT;
        SC_RIGHT: char_next = CH_RIGHT;
        default:  char_next = CH_NONE;
      endcase
    end else begin
      case (scancode) inside
        SC_LSHIFT, SC_RSHIFT:         shift_flag_next = 1'b1;
        SC_LSHIFT_REL, SC_RSHIFT_REL: shift_flag_next = 1'b0;
        SC_CTRL:                      ctrl_flag_next = 1'b1;
        SC_CTRL_REL:                  ctrl_flag_next = 1'b0;
        SC_ALT: begin
          alt_flag_next    = 1'b1;
          layout_flag_next = ~layout_flag;
        end
        SC_ALT_REL:                   alt_flag_next = 1'b0;
        SC_CAPS:                      caps_flag_next = ~caps_flag;
        SC_ENTER:                     char_next = CH_NEWLINE;
        SC_BACKSPACE:                 char_next = CH_BACKSPACE;
        SC_TAB:                       char_next = CH_TAB;
        SC_SPACE:                     char_next = CH_SPACE;
        SC_ESCAPE:                    char_next = CH_ESCAPE;
        default: begin
          // Other releases give nothing; presses go through the tables.
          if (!scancode[7]) begin
            char_next = looked_up;
            if (caps_flag) begin
              if (looked_up >= CH_LOWER_A && looked_up <= CH_LOWER_Z) begin
                char_next = looked_up - CASE_OFFSET;
              end else if (looked_up >= CH_UPPER_A && looked_up <= CH_UPPER_Z &&
                           shift_flag) begin
                char_next = looked_up + CASE_OFFSET;
              end
            end
          end
        end
      endcase
    end
  end

  // Flag state, updated once per accepted item.
  always_ff @(posedge clk) begin
    if (rst) begin
      shift_flag     <= 1'b0;
      ctrl_flag      <= 1'b0;
      alt_flag       <= 1'b0;
      caps_flag      <= 1'b0;
      prefix_pending <= 1'b0;
      layout_flag    <= 1'b0;
    end else if (in_acc) begin
      shift_flag     <= shift_flag_next;
      ctrl_flag      <= ctrl_flag_next;
      alt_flag       <= alt_flag_next;
      caps_flag      <= caps_flag_next;
      prefix_pending <= prefix_pending_next;
      layout_flag    <= layout_flag_next;
    end
  end

  // Result register valid bit.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Result character; the flags shown are those left by the same item.
  always_ff @(posedge clk) begin
    if (in_acc) begin
      char_reg <= char_next;
    end
  end

  assign char_code  = char_reg;
  assign shift_held = shift_flag;
  assign ctrl_held  = ctrl_flag;
  assign alt_held   = alt_flag;
  assign caps_on    = caps_flag;
  assign alt_layout = layout_flag;

  // The byte after a prefix always consumes it.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && prefix_pending && scancode != SC_PREFIX) |=> !prefix_pending)
    else $error("prefix flag not cleared by the byte after it");

  // An unprefixed alt press flips the layout.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && !prefix_pending && scancode == SC_ALT) |=>
      (alt_layout != $past(alt_layout)) && alt_held)
    else $error("alt press did not flip the layout");

  // A release byte never produces a character.
  assert property (@(posedge clk) disable iff (rst)
    (in_acc && scancode[7]) |=> (char_code == CH_NONE))
    else $error("release byte produced a character");

  // Flags move only when an item is accepted.
  assert property (@(posedge clk) disable iff (rst)
    !in_acc |=> $stable({shift_flag, ctrl_flag, alt_flag, caps_flag,
                         prefix_pending, layout_flag}))
    else $error("flags changed without an accepted item");

endmodule
